FILE: hdl/masked_byte_pattern_scan_core_macros.svh
// assertion helpers for the pattern scan core
`ifndef MASKED_BYTE_PATTERN_SCAN_CORE_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MBPS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MBPS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mbps_pkg.sv
package mbps_pkg;

  localparam int MAX_LEN_DEF         = 64;
  localparam int SCAN_LIMIT_LOG2_DEF = 26;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 7;
  localparam int START_W = 26;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_LOAD    = 2'd0;
  localparam cmd_t CMD_SCAN    = 2'd1;
  localparam cmd_t CMD_RESTART = 2'd2;

  // per-cycle control broadcast to every cell of the ring
  typedef struct packed {
    logic              shift;
    logic              rot;
    logic              load;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic              care;
  } mbps_ctrl_t;

endpackage

FILE: hdl/mbps_in_if.sv
interface mbps_in_if;
  logic                            valid;
  logic                            ready;
  mbps_pkg::cmd_t                  cmd;
  logic [mbps_pkg::IDX_W-1:0]      entry_index;
  logic [mbps_pkg::BYTE_W-1:0]     byte_value;
  logic                            care;

  modport source (output valid, cmd, entry_index, byte_value, care, input ready);
  modport sink   (input valid, cmd, entry_index, byte_value, care, output ready);
endinterface

FILE: hdl/mbps_out_if.sv
interface mbps_out_if;
  logic                             valid;
  logic                             ready;
  logic                             matched;
  logic [mbps_pkg::START_W-1:0]     match_start;

  modport source (output valid, matched, match_start, input ready);
  modport sink   (input valid, matched, match_start, output ready);
endinterface

FILE: hdl/masked_byte_pattern_scan_core.sv
// Wildcard byte signature scanner. Words arrive on in_i: a load word writes one pattern byte and
// its care bit, a scan word pushes one stream byte, a restart word starts a new region at offset
// zero. Every accepted word yields exactly one result word on out_o, registered in stage 1 and then
// in the output register; only a scan word that completes a match of the last pattern_length bytes
// reports matched = 1 with the start offset of that window, everything else reports zeros. Throughput
// is one word per clock, limited by output back-pressure and by ring rotation. The window lives in a
// ring of MAX_LEN cells; writing pattern_length re-aligns the ring by rotating it one position per
// clock through (old length - new length) mod MAX_LEN positions, up to MAX_LEN-1, with in_i.ready
// low meanwhile. No clearing pass is needed after reset.
`include "masked_byte_pattern_scan_core_macros.svh"

module masked_byte_pattern_scan_core #(
  parameter int MAX_LEN         = mbps_pkg::MAX_LEN_DEF,
  parameter int SCAN_LIMIT_LOG2 = mbps_pkg::SCAN_LIMIT_LOG2_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mbps_in_if.sink                      in_i,
  mbps_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [mbps_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int SEEN_W  = SCAN_LIMIT_LOG2 + 1;
  localparam int SUM_W   = LEN_W + 2;
  localparam int START_W = mbps_pkg::START_W;

  // ---------------------------------------------------------------
  // length register and ring re-alignment
  // ---------------------------------------------------------------
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rot_q, rot_d;
  logic [LEN_W-1:0] cfg_len;
  logic [SUM_W-1:0] rot_sum;
  logic [SUM_W-1:0] rot_mod;
  logic             busy;

  // clamp the written length into 1..MAX_LEN
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_len = LEN_W'(1);
    end else if (32'(cfg_wdata_i) > MAX_LEN) begin
      cfg_len = LEN_W'(MAX_LEN);
    end else begin
      cfg_len = LEN_W'(cfg_wdata_i);
    end
  end

  // each rotation step lowers the ring's alignment length by one (mod MAX_LEN),
  // so pending steps accumulate across back-to-back writes
  assign rot_sum = SUM_W'(rot_q) + SUM_W'(len_q) + SUM_W'(MAX_LEN) - SUM_W'(cfg_len);

  always_comb begin
    if (rot_sum >= SUM_W'(2 * MAX_LEN)) begin
      rot_mod = rot_sum - SUM_W'(2 * MAX_LEN);
    end else if (rot_sum >= SUM_W'(MAX_LEN)) begin
      rot_mod = rot_sum - SUM_W'(MAX_LEN);
    end else begin
      rot_mod = rot_sum;
    end
  end

  assign busy = (rot_q != '0);

  always_comb begin
    len_d = len_q;
    rot_d = rot_q;
    if (cfg_we_i) begin
      len_d = cfg_len;
      rot_d = LEN_W'(rot_mod);
    end else if (busy) begin
      rot_d = rot_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
      rot_q <= '0;
    end else begin
      len_q <= len_d;
      rot_q <= rot_d;
    end
  end

  // ---------------------------------------------------------------
  // handshake: stage 1 holds the word whose window sits in the ring,
  // the output register holds the finished result
  // ---------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic s1_ok_q;
  logic [START_W-1:0] s1_start_q;
  logic out_valid_q, out_valid_d;
  logic out_matched_q;
  logic [START_W-1:0] out_start_q;
  logic adv;
  logic acc;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = !busy && (!s1_valid_q || adv);
  assign acc        = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------
  // command decode and region byte count
  // ---------------------------------------------------------------
  logic               is_scan;
  logic               is_load;
  logic               is_restart;
  logic               scan_go;
  logic [SEEN_W-1:0]  seen_q, seen_d;
  logic [SEEN_W-1:0]  seen_inc;
  logic [SEEN_W-1:0]  start_full;
  logic               enough;
  logic               start_sat;
  logic [START_W-1:0] start_val;

  always_comb begin
    is_scan    = 1'b0;
    is_load    = 1'b0;
    is_restart = 1'b0;
    case (in_i.cmd)
      mbps_pkg::CMD_LOAD:    is_load    = 1'b1;
      mbps_pkg::CMD_SCAN:    is_scan    = 1'b1;
      mbps_pkg::CMD_RESTART: is_restart = 1'b1;
      default: ;
    endcase
  end

  // a scan at the walk limit is dropped without shifting
  assign scan_go    = acc && is_scan && !seen_q[SEEN_W-1];
  assign seen_inc   = seen_q + SEEN_W'(1);
  assign enough     = (seen_inc >= SEEN_W'(len_q));
  assign start_full = seen_inc - SEEN_W'(len_q);
  assign start_sat  = ((start_full >> START_W) != '0);
  assign start_val  = start_sat ? '1 : START_W'(start_full);

  // stale window bytes are never compared: a match needs the count to reach the length,
  // so a restart only has to clear the count
  always_comb begin
    seen_d = seen_q;
    if (acc && is_restart) begin
      seen_d = '0;
    end else if (scan_go) begin
      seen_d = seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // ---------------------------------------------------------------
  // ring of cells: window byte, pattern byte and care bit per position
  // ---------------------------------------------------------------
  mbps_pkg::mbps_ctrl_t        ctrl;
  logic [mbps_pkg::BYTE_W-1:0] win [MAX_LEN];
  logic [MAX_LEN-1:0]          hit;
  logic                        win_ok;

  always_comb begin
    ctrl.shift = scan_go;
    ctrl.rot   = busy && !cfg_we_i;
    ctrl.load  = acc && is_load;
    ctrl.idx   = in_i.entry_index;
    ctrl.data  = in_i.byte_value;
    ctrl.care  = in_i.care;
  end

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    mbps_cell #(
      .MAX_LEN (MAX_LEN),
      .INDEX   (j),
      .LEN_W   (LEN_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .len_i    (len_q),
      .nb_win_i (win[(j + 1) % MAX_LEN]),
      .win_o    (win[j]),
      .hit_o    (hit[j])
    );
  end

  // every position inside the length either is a wildcard or equals its window byte
  assign win_ok = &hit;

  // ---------------------------------------------------------------
  // stage 1 and output register
  // ---------------------------------------------------------------
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // compare reads the ring before the next word's shift lands
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ok_q    <= scan_go && enough;
      s1_start_q <= start_val;
    end
    if (adv) begin
      out_matched_q <= s1_ok_q && win_ok;
      out_start_q   <= (s1_ok_q && win_ok) ? s1_start_q : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.matched     = out_matched_q;
  assign out_o.match_start = out_start_q;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  `MBPS_ASSERT_IMP(a_rot_blocks_input, clk_i, rst_ni, busy, !in_i.ready, "word taken during ring rotation")
  `MBPS_ASSERT_IMP(a_seen_in_range, clk_i, rst_ni, seen_q[SEEN_W-1], seen_q[SEEN_W-2:0] == '0, "byte count past walk limit")
  `MBPS_ASSERT_IMP(a_start_zero, clk_i, rst_ni, out_valid_q && !out_matched_q, out_start_q == '0, "offset on a non-match")
  `MBPS_ASSERT_NXT(a_accept_fills_s1, clk_i, rst_ni, acc, s1_valid_q, "accepted word lost before stage 1")

endmodule

FILE: hdl/mbps_cell.sv
module mbps_cell #(
  parameter int MAX_LEN = mbps_pkg::MAX_LEN_DEF,
  parameter int INDEX   = 0,
  parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbps_pkg::mbps_ctrl_t          ctrl_i,
  input  logic [LEN_W-1:0]              len_i,
  input  logic [mbps_pkg::BYTE_W-1:0]   nb_win_i,
  output logic [mbps_pkg::BYTE_W-1:0]   win_o,
  output logic                          hit_o
);

  logic [mbps_pkg::BYTE_W-1:0] win_q, win_d;
  logic [mbps_pkg::BYTE_W-1:0] pat_q;
  logic                        care_q;
  logic                        inject;
  logic                        active;
  logic                        load_here;

  // newest byte enters at position len-1
  assign inject    = (LEN_W'(INDEX + 1) == len_i);
  assign active    = (LEN_W'(INDEX) < len_i);
  assign load_here = ctrl_i.load && (32'(ctrl_i.idx) == INDEX);

  always_comb begin
    win_d = win_q;
    if (ctrl_i.shift) begin
      win_d = inject ? ctrl_i.data : nb_win_i;
    end else if (ctrl_i.rot) begin
      win_d = nb_win_i;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (load_here) begin
      pat_q <= ctrl_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      care_q <= 1'b1;
    end else if (load_here) begin
      care_q <= ctrl_i.care;
    end
  end

  assign win_o = win_q;
  assign hit_o = !active || !care_q || (pat_q == win_q);

endmodule
